>>> design/ppp_pkg.sv
// ----------------------------------------------------------------------------
// ppp_pkg: shared types and constants for the point projection pipeline
// Holds the register indexes, datapath widths and the tag carried with
// each point through the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package ppp_pkg;

  // Configuration register indexes
  localparam logic [3:0] REG_QUAT_W = 4'd0;
  localparam logic [3:0] REG_QUAT_X = 4'd1;
  localparam logic [3:0] REG_QUAT_Y = 4'd2;
  localparam logic [3:0] REG_QUAT_Z = 4'd3;
  localparam logic [3:0] REG_SHIFT_X = 4'd4;
  localparam logic [3:0] REG_SHIFT_Y = 4'd5;
  localparam logic [3:0] REG_SHIFT_Z = 4'd6;
  localparam logic [3:0] REG_FOCAL = 4'd7;

  // Divider widths: numerator magnitude, positive depth, quotient bits
  localparam int NUM_W = 56;
  localparam int DEN_W = 38;
  localparam int Q_W = 17;
  localparam int REM_W = NUM_W + 1;

  // Side information that travels with each point through the divider
  typedef struct packed {
    logic valid;
    logic front;
    logic neg_u;
    logic neg_v;
    logic big_u;
    logic big_v;
  } ppp_tag_t;

endpackage

`default_nettype wire

>>> design/ppp_divider.sv
// ----------------------------------------------------------------------------
// ppp_divider: pipelined restoring divider for both pixel coordinates
// One quotient bit per stage, most significant first; both axes share the
// depth as divisor. The numerators must be below depth * 2^Q_W.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_divider
  import ppp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num_u,
  input  wire logic [NUM_W-1:0] num_v,
  input  wire logic [DEN_W-1:0] den,
  input  wire ppp_tag_t         tag_in,
  output logic      [Q_W-1:0]   quo_u,
  output logic      [Q_W-1:0]   quo_v,
  output ppp_tag_t              tag_out
);

  logic [REM_W-1:0] rem_u [Q_W+1];
  logic [REM_W-1:0] rem_v [Q_W+1];
  logic [Q_W-1:0]   q_u   [Q_W+1];
  logic [Q_W-1:0]   q_v   [Q_W+1];
  logic [DEN_W-1:0] den_p [Q_W+1];
  ppp_tag_t         tag_p [Q_W+1];

  assign rem_u[0] = REM_W'(num_u);
  assign rem_v[0] = REM_W'(num_v);
  assign q_u[0]   = '0;
  assign q_v[0]   = '0;
  assign den_p[0] = den;
  assign tag_p[0] = tag_in;

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int B = Q_W - 1 - s;
    logic [REM_W-1:0] dsh;
    logic             ge_u, ge_v;

    assign dsh  = REM_W'(den_p[s]) << B;
    assign ge_u = rem_u[s] >= dsh;
    assign ge_v = rem_v[s] >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_u[s+1] <= ge_u ? rem_u[s] - dsh : rem_u[s];
        rem_v[s+1] <= ge_v ? rem_v[s] - dsh : rem_v[s];
        q_u[s+1]   <= {q_u[s][Q_W-2:0], ge_u};
        q_v[s+1]   <= {q_v[s][Q_W-2:0], ge_v};
        den_p[s+1] <= den_p[s];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_p[s+1] <= '0;
      end else if (en) begin
        tag_p[s+1] <= tag_p[s];
      end
    end
  end

  assign quo_u   = q_u[Q_W];
  assign quo_v   = q_v[Q_W];
  assign tag_out = tag_p[Q_W];

endmodule

`default_nettype wire

>>> design/pinhole_point_projection.sv
// ----------------------------------------------------------------------------
// pinhole_point_projection: world point to pixel projection pipeline
// Subtracts the camera translation, rotates by the transposed quaternion
// matrix, applies focal length and principal point, divides by depth.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one world point per transfer, tdata = {z, y, x}, each
//   signed Q16.16. Master stream: one result per point, tdata = {v, u} as
//   signed 16-bit pixels, tuser = {clipped, in_front}.
//   Configuration: write cfg_data to register cfg_index while cfg_we is
//   high; indexes above 7 are dropped. Write only while the pipe is empty.
//   The rotation matrix is rebuilt from the quaternion in the cycle after a
//   write.
//   Pipeline: the 23 register stages from the input transfer to m_tvalid
//   are five arithmetic stages (translate, matrix multiply, sum, scale,
//   magnitude), seventeen divider stages (one quotient bit each) and the
//   output register. One point is accepted every cycle while the receiver
//   does not stall.
//   When the receiver stalls, the whole pipe holds and s_tready drops;
//   nothing is lost or repeated. Reset clears all valid bits and loads the
//   default camera pose and focal length.
// ----------------------------------------------------------------------------
`default_nettype none

module pinhole_point_projection
  import ppp_pkg::*;
#(
  parameter int CENTER_U = 190,
  parameter int CENTER_V = 160
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // input points
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [95:0] s_tdata,   // world_x[31:0], world_y[63:32], world_z[95:64]
  // output pixels
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // pixel_u[15:0], pixel_v[31:16]
  output logic [1:0]       m_tuser    // in_front[0], clipped[1]
);

  localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;
  localparam logic signed [33:0] RLIM    = 34'sd1073741824;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
  logic signed [31:0] shift_x, shift_y, shift_z;
  logic        [15:0] focal_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_w       <= -16'sd8192;
      quat_x       <= 16'sd8192;
      quat_y       <= 16'sd8192;
      quat_z       <= -16'sd8192;
      shift_x      <= 32'sd131072;
      shift_y      <= 32'sd131072;
      shift_z      <= 32'sd131072;
      focal_length <= 16'd400;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_QUAT_W:  quat_w       <= cfg_data[15:0];
        REG_QUAT_X:  quat_x       <= cfg_data[15:0];
        REG_QUAT_Y:  quat_y       <= cfg_data[15:0];
        REG_QUAT_Z:  quat_z       <= cfg_data[15:0];
        REG_SHIFT_X: shift_x      <= cfg_data;
        REG_SHIFT_Y: shift_y      <= cfg_data;
        REG_SHIFT_Z: shift_z      <= cfg_data;
        REG_FOCAL:   focal_length <= cfg_data[15:0];
        default:     ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Rotation matrix, Q.28, rebuilt every cycle from the quaternion
  // --------------------------------------------------------------------------
  function automatic logic signed [31:0] clamp_r(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > RLIM) begin
      r = RLIM[31:0];
    end else if (v < -RLIM) begin
      r = 32'(-RLIM);
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic signed [31:0] pxx, pyy, pzz, pxy, pxz, pyz, pwx, pwy, pwz;
  assign pxx = quat_x * quat_x;
  assign pyy = quat_y * quat_y;
  assign pzz = quat_z * quat_z;
  assign pxy = quat_x * quat_y;
  assign pxz = quat_x * quat_z;
  assign pyz = quat_y * quat_z;
  assign pwx = quat_w * quat_x;
  assign pwy = quat_w * quat_y;
  assign pwz = quat_w * quat_z;

  logic signed [31:0] mat [3][3];

  always_ff @(posedge clk) begin
    mat[0][0] <= clamp_r(ONE_Q28 - ((34'(pyy) + 34'(pzz)) <<< 1));
    mat[0][1] <= clamp_r((34'(pxy) - 34'(pwz)) <<< 1);
    mat[0][2] <= clamp_r((34'(pxz) + 34'(pwy)) <<< 1);
    mat[1][0] <= clamp_r((34'(pxy) + 34'(pwz)) <<< 1);
    mat[1][1] <= clamp_r(ONE_Q28 - ((34'(pxx) + 34'(pzz)) <<< 1));
    mat[1][2] <= clamp_r((34'(pyz) - 34'(pwx)) <<< 1);
    mat[2][0] <= clamp_r((34'(pxz) - 34'(pwy)) <<< 1);
    mat[2][1] <= clamp_r((34'(pyz) + 34'(pwx)) <<< 1);
    mat[2][2] <= clamp_r(ONE_Q28 - ((34'(pxx) + 34'(pyy)) <<< 1));
  end

  // --------------------------------------------------------------------------
  // Pipeline control: every stage advances together when the output can move
  // --------------------------------------------------------------------------
  logic en;
  logic v1, v2, v3, v4;
  ppp_tag_t tag5, tag_div;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Stage 1: translate into camera origin (exact, 33 bits)
  logic signed [32:0] dv [3];

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= 33'(signed'(s_tdata[31:0])) - 33'(shift_x);
      dv[1] <= 33'(signed'(s_tdata[63:32])) - 33'(shift_y);
      dv[2] <= 33'(signed'(s_tdata[95:64])) - 33'(shift_z);
    end
  end

  // Stage 2: nine products by the transposed matrix, floored to Q.30
  logic signed [50:0] term [3][3];

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      logic signed [64:0] pfull;
      assign pfull = 65'(mat[j][i]) * 65'(dv[j]);
      always_ff @(posedge clk) begin
        if (en) begin
          term[i][j] <= pfull[64:14];
        end
      end
    end
  end

  // Stage 3: sum per axis and floor to Q.16
  logic signed [38:0] cam [3];

  for (genvar i = 0; i < 3; i++) begin : g_sum
    logic signed [52:0] acc;
    assign acc = 53'(term[i][0]) + 53'(term[i][1]) + 53'(term[i][2]);
    always_ff @(posedge clk) begin
      if (en) begin
        cam[i] <= acc[52:14];
      end
    end
  end

  // Stage 4: scale by focal length and add principal point times depth
  logic signed [16:0] foc_s;
  logic signed [16:0] cen_u, cen_v;
  logic signed [55:0] nu, nv;
  logic signed [38:0] cz4;
  logic               front4;

  assign foc_s = signed'({1'b0, focal_length});
  assign cen_u = 17'(CENTER_U);
  assign cen_v = 17'(CENTER_V);

  always_ff @(posedge clk) begin
    if (en) begin
      nu     <= 56'(cam[0]) * 56'(foc_s) + 56'(cam[2]) * 56'(cen_u);
      nv     <= 56'(cam[1]) * 56'(foc_s) + 56'(cam[2]) * 56'(cen_v);
      cz4    <= cam[2];
      front4 <= cam[2] > 39'sd0;
    end
  end

  // Stage 5: magnitudes and overflow check against depth * 2^17
  logic [NUM_W-1:0] mag_u_c, mag_v_c, mag_u, mag_v;
  logic [DEN_W-1:0] den_c, den5;
  logic [REM_W-1:0] lim_c;

  assign mag_u_c = nu[55] ? NUM_W'(-nu) : NUM_W'(nu);
  assign mag_v_c = nv[55] ? NUM_W'(-nv) : NUM_W'(nv);
  assign den_c   = cz4[DEN_W-1:0];
  assign lim_c   = REM_W'(den_c) << Q_W;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_u <= mag_u_c;
      mag_v <= mag_v_c;
      den5  <= den_c;
    end
  end

  // The stage 5 valid bit travels in the tag
  always_ff @(posedge clk) begin
    if (rst) begin
      tag5 <= '0;
    end else if (en) begin
      tag5.valid <= v4;
      tag5.front <= front4;
      tag5.neg_u <= nu[55];
      tag5.neg_v <= nv[55];
      tag5.big_u <= REM_W'(mag_u_c) >= lim_c;
      tag5.big_v <= REM_W'(mag_v_c) >= lim_c;
    end
  end

  // Divider: seventeen stages, one quotient bit each
  logic [Q_W-1:0] quo_u, quo_v;

  ppp_divider u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .num_u   (mag_u),
    .num_v   (mag_v),
    .den     (den5),
    .tag_in  (tag5),
    .quo_u   (quo_u),
    .quo_v   (quo_v),
    .tag_out (tag_div)
  );

  // --------------------------------------------------------------------------
  // Output: sign, saturate, zero when behind the camera
  // --------------------------------------------------------------------------
  function automatic logic [16:0] sat_pix(input logic [Q_W-1:0] q, input logic neg,
                                          input logic big);
    logic [16:0] r;
    if (neg) begin
      if (big || q > 17'd32768) begin
        r = {1'b1, 16'h8000};
      end else begin
        r = {1'b0, 16'(-q)};
      end
    end else begin
      if (big || q > 17'd32767) begin
        r = {1'b1, 16'h7fff};
      end else begin
        r = {1'b0, q[15:0]};
      end
    end
    return r;
  endfunction

  logic [16:0] su, sv;
  assign su = sat_pix(quo_u, tag_div.neg_u, tag_div.big_u);
  assign sv = sat_pix(quo_v, tag_div.neg_v, tag_div.big_v);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= tag_div.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (tag_div.front) begin
        m_tdata <= {sv[15:0], su[15:0]};
        m_tuser <= {su[16] | sv[16], 1'b1};
      end else begin
        m_tdata <= '0;
        m_tuser <= '0;
      end
    end
  end

endmodule

`default_nettype wire
